/* design/ptls_pkg.sv */
// ============================================================================
// ptls_pkg
// Shared types and constants of the pedestrian traffic light sequencer:
// lamp masks, control step codes, register indexes and the control state.
// ============================================================================
`default_nettype none

package ptls_pkg;

    // Default width of the tick counter and of the stored limits.
    localparam int COUNT_WIDTH_DEFAULT = 8;

    // Configuration registers are eight bits wide.
    localparam int CFG_DATA_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 2;

    // Every timing register comes out of reset at 20 ticks.
    localparam logic [CFG_DATA_WIDTH-1:0] CFG_RESET_TICKS = 8'd20;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_TICKS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BLINK_TICKS = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_TICKS  = 2'd2;

    // Lamp vector, one bit per lamp, 1 means lit.
    typedef logic [5:0] lamps_t;

    localparam lamps_t LAMP_CG = 6'b000001;
    localparam lamps_t LAMP_CY = 6'b000010;
    localparam lamps_t LAMP_CR = 6'b000100;
    localparam lamps_t LAMP_PG = 6'b001000;
    localparam lamps_t LAMP_PY = 6'b010000;
    localparam lamps_t LAMP_PR = 6'b100000;

    // Car phases.
    localparam logic [1:0] PHASE_RED      = 2'd0;
    localparam logic [1:0] PHASE_YELLOW_A = 2'd1;
    localparam logic [1:0] PHASE_GREEN    = 2'd2;
    localparam logic [1:0] PHASE_YELLOW_B = 2'd3;

    // Control steps inside a car phase.
    typedef enum logic [2:0] {
        SUB_POLL    = 3'd0,
        SUB_XBLINK  = 3'd1,
        SUB_XHOLD   = 3'd2,
        SUB_FBLINK  = 3'd3,
        SUB_FHOLD   = 3'd4,
        SUB_FBLINK1 = 3'd5
    } sub_step_t;

    // Control state apart from the tick counter.
    typedef struct packed {
        logic [1:0] car_phase;
        sub_step_t  sub_step;
        logic       request_pending;
        logic       crossing_followup;
        lamps_t     lamps;
    } ctrl_t;

endpackage

`default_nettype wire

/* design/ptls_cfg_regs.sv */
// ============================================================================
// ptls_cfg_regs
// Configuration registers. Each write stores the tick limit that the
// sequencer compares against: zero reads as one, and values above the
// counter range saturate at its top.
// ============================================================================
`default_nettype none

module ptls_cfg_regs #(
    parameter int COUNT_WIDTH = ptls_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [ptls_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire  [ptls_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output logic [COUNT_WIDTH-1:0]                phase_lim,
    output logic [COUNT_WIDTH-1:0]                blink_lim,
    output logic [COUNT_WIDTH-1:0]                hold_lim
);

    // Turns a register value into a usable tick limit.
    function automatic logic [COUNT_WIDTH-1:0] limit_of(
        input logic [ptls_pkg::CFG_DATA_WIDTH-1:0] r
    );
        logic [15:0] v;
        logic [15:0] cmax;
        v = {8'd0, r};
        cmax = 16'((32'd1 << COUNT_WIDTH) - 32'd1);
        if (v == 16'd0) begin
            v = 16'd1;
        end
        if (v > cmax) begin
            v = cmax;
        end
        return v[COUNT_WIDTH-1:0];
    endfunction

    logic [COUNT_WIDTH-1:0] phase_lim_reg;
    logic [COUNT_WIDTH-1:0] blink_lim_reg;
    logic [COUNT_WIDTH-1:0] hold_lim_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register write decoder; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_lim_reg <= limit_of(ptls_pkg::CFG_RESET_TICKS);
            blink_lim_reg <= limit_of(ptls_pkg::CFG_RESET_TICKS);
            hold_lim_reg  <= limit_of(ptls_pkg::CFG_RESET_TICKS);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ptls_pkg::REG_PHASE_TICKS: phase_lim_reg <= limit_of(cfg_data);
                ptls_pkg::REG_BLINK_TICKS: blink_lim_reg <= limit_of(cfg_data);
                ptls_pkg::REG_HOLD_TICKS:  hold_lim_reg  <= limit_of(cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign phase_lim = phase_lim_reg;
    assign blink_lim = blink_lim_reg;
    assign hold_lim  = hold_lim_reg;

endmodule

`default_nettype wire

/* design/ptls_step.sv */
// ============================================================================
// ptls_step
// Next-state logic for one tick. Control steps that take no time (phase
// changes, entering a crossing or a follow-up) are resolved in the same
// tick; at most two of them precede the step that consumes the tick, so
// three short resolution passes cover every case.
// ============================================================================
`default_nettype none

module ptls_step #(
    parameter int COUNT_WIDTH = ptls_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire  ptls_pkg::ctrl_t         ctrl,
    input  wire  [COUNT_WIDTH-1:0]        cnt,
    input  wire                           button_pressed,
    input  wire  [COUNT_WIDTH-1:0]        phase_lim,
    input  wire  [COUNT_WIDTH-1:0]        blink_lim,
    input  wire  [COUNT_WIDTH-1:0]        hold_lim,
    output ptls_pkg::ctrl_t               ctrl_next,
    output logic [COUNT_WIDTH-1:0]        cnt_next
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    typedef struct packed {
        ptls_pkg::ctrl_t        c;
        logic [COUNT_WIDTH-1:0] cnt;
        logic                   ticked;
    } pass_t;

    // Moves to the next car phase and restarts polling.
    function automatic pass_t next_phase(input pass_t s_in);
        pass_t s;
        s = s_in;
        s.c.car_phase = s.c.car_phase + 2'd1;
        s.c.sub_step = ptls_pkg::SUB_POLL;
        s.cnt = '0;
        return s;
    endfunction

    // Enters a new step with a cleared tick counter.
    function automatic pass_t go(input pass_t s_in, input ptls_pkg::sub_step_t nxt);
        pass_t s;
        s = s_in;
        s.c.sub_step = nxt;
        s.cnt = '0;
        return s;
    endfunction

    // Consumes the tick: counts it and stops further resolution.
    function automatic pass_t take_tick(input pass_t s_in);
        pass_t s;
        s = s_in;
        s.cnt = s.cnt + CNT_ONE;
        s.ticked = 1'b1;
        return s;
    endfunction

    // One resolution pass; does nothing once the tick has been consumed.
    function automatic pass_t resolve(
        input pass_t                  s_in,
        input logic [COUNT_WIDTH-1:0] plim,
        input logic [COUNT_WIDTH-1:0] blim,
        input logic [COUNT_WIDTH-1:0] hlim
    );
        pass_t      s;
        logic [1:0] p;
        s = s_in;
        p = s.c.car_phase;
        if (!s.ticked) begin
            unique case (s.c.sub_step)
                // Crossing blink: both yellows toggle.
                ptls_pkg::SUB_XBLINK: begin
                    if (s.cnt < blim) begin
                        s.c.lamps = s.c.lamps ^ (ptls_pkg::LAMP_CY | ptls_pkg::LAMP_PY);
                        s = take_tick(s);
                    end else begin
                        s.c.lamps = s.c.lamps & ~(ptls_pkg::LAMP_CY | ptls_pkg::LAMP_PY
                                                  | ptls_pkg::LAMP_PR);
                        if (p == ptls_pkg::PHASE_GREEN) begin
                            s.c.lamps = s.c.lamps & ~ptls_pkg::LAMP_CG;
                        end
                        s.c.lamps = s.c.lamps | ptls_pkg::LAMP_PG | ptls_pkg::LAMP_CR;
                        s = go(s, ptls_pkg::SUB_XHOLD);
                    end
                end
                // Pedestrian green hold; its end drops any press seen meanwhile.
                ptls_pkg::SUB_XHOLD: begin
                    if (s.cnt < hlim) begin
                        s = take_tick(s);
                    end else begin
                        s.c.lamps = s.c.lamps & ~ptls_pkg::LAMP_PG;
                        if (p != ptls_pkg::PHASE_RED) begin
                            s.c.lamps = s.c.lamps & ~ptls_pkg::LAMP_CR;
                        end
                        s.c.request_pending = 1'b0;
                        s.c.crossing_followup = 1'b1;
                        s = next_phase(s);
                    end
                end
                // Follow-up blink after a crossing.
                ptls_pkg::SUB_FBLINK: begin
                    if (s.cnt < blim) begin
                        s.c.lamps = s.c.lamps ^ (ptls_pkg::LAMP_CY | ptls_pkg::LAMP_PY);
                        s = take_tick(s);
                    end else if (p == ptls_pkg::PHASE_YELLOW_A) begin
                        s.c.crossing_followup = 1'b0;
                        s = next_phase(s);
                    end else begin
                        if (p == ptls_pkg::PHASE_YELLOW_B) begin
                            s.c.lamps = s.c.lamps & ~ptls_pkg::LAMP_PG;
                        end
                        s.c.lamps = s.c.lamps | ptls_pkg::LAMP_PR | ptls_pkg::LAMP_CG;
                        s = go(s, ptls_pkg::SUB_FHOLD);
                    end
                end
                // Car green hold of a follow-up.
                ptls_pkg::SUB_FHOLD: begin
                    if (s.cnt < hlim) begin
                        s = take_tick(s);
                    end else if (p == ptls_pkg::PHASE_YELLOW_B) begin
                        s.c.lamps = s.c.lamps & ~ptls_pkg::LAMP_CG;
                        s = go(s, ptls_pkg::SUB_FBLINK1);
                    end else begin
                        s.c.crossing_followup = 1'b0;
                        s = next_phase(s);
                    end
                end
                // Final car yellow blink of the follow-up in the last phase.
                ptls_pkg::SUB_FBLINK1: begin
                    if (s.cnt < blim) begin
                        s.c.lamps = s.c.lamps ^ ptls_pkg::LAMP_CY;
                        s = take_tick(s);
                    end else begin
                        s.c.crossing_followup = 1'b0;
                        s = next_phase(s);
                    end
                end
                // Polling, also taken for codes that cannot occur.
                default: begin
                    s.c.sub_step = ptls_pkg::SUB_POLL;
                    if (s.cnt >= plim) begin
                        s = next_phase(s);
                    end else if (s.c.crossing_followup) begin
                        if (p == ptls_pkg::PHASE_YELLOW_A) begin
                            s.c.lamps = s.c.lamps & ~ptls_pkg::LAMP_CR;
                        end
                        s = go(s, ptls_pkg::SUB_FBLINK);
                    end else if (!s.c.request_pending) begin
                        s.c.lamps = s.c.lamps | ptls_pkg::LAMP_PR;
                        case (p)
                            ptls_pkg::PHASE_RED: begin
                                s.c.lamps = (s.c.lamps & ~ptls_pkg::LAMP_CG)
                                            | ptls_pkg::LAMP_CR;
                            end
                            ptls_pkg::PHASE_YELLOW_A: begin
                                s.c.lamps = (s.c.lamps & ~(ptls_pkg::LAMP_CR
                                                           | ptls_pkg::LAMP_PY))
                                            ^ ptls_pkg::LAMP_CY;
                            end
                            ptls_pkg::PHASE_GREEN: begin
                                s.c.lamps = (s.c.lamps & ~(ptls_pkg::LAMP_CR
                                                           | ptls_pkg::LAMP_CY))
                                            | ptls_pkg::LAMP_CG;
                            end
                            default: begin
                                s.c.lamps = (s.c.lamps & ~ptls_pkg::LAMP_CG)
                                            ^ ptls_pkg::LAMP_CY;
                            end
                        endcase
                        s = take_tick(s);
                    end else begin
                        case (p)
                            ptls_pkg::PHASE_RED: begin
                                s.c.lamps = (s.c.lamps & ~ptls_pkg::LAMP_PR)
                                            | ptls_pkg::LAMP_CR | ptls_pkg::LAMP_PG;
                                s = go(s, ptls_pkg::SUB_XHOLD);
                            end
                            ptls_pkg::PHASE_YELLOW_A: begin
                                s.c.lamps = s.c.lamps & ~(ptls_pkg::LAMP_CY
                                                          | ptls_pkg::LAMP_PY
                                                          | ptls_pkg::LAMP_CR);
                                s = go(s, ptls_pkg::SUB_XBLINK);
                            end
                            default: begin
                                s.c.lamps = s.c.lamps & ~(ptls_pkg::LAMP_PR
                                                          | ptls_pkg::LAMP_CG
                                                          | ptls_pkg::LAMP_CY
                                                          | ptls_pkg::LAMP_PY);
                                s = go(s, ptls_pkg::SUB_XBLINK);
                            end
                        endcase
                    end
                end
            endcase
        end
        return s;
    endfunction

    pass_t pass0;
    pass_t pass1;
    pass_t pass2;
    pass_t pass3;

    // The press is latched first, then the control flow runs to the next tick.
    always_comb begin
        pass0 = '{c: ctrl, cnt: cnt, ticked: 1'b0};
        pass0.c.request_pending = ctrl.request_pending | button_pressed;
        pass1 = resolve(pass0, phase_lim, blink_lim, hold_lim);
        pass2 = resolve(pass1, phase_lim, blink_lim, hold_lim);
        pass3 = resolve(pass2, phase_lim, blink_lim, hold_lim);
    end

    assign ctrl_next = pass3.c;
    assign cnt_next  = pass3.cnt;

endmodule

`default_nettype wire

/* design/pedestrian_traffic_light_sequencer.sv */
// ============================================================================
// pedestrian_traffic_light_sequencer
// Car and pedestrian lamp sequencer driven by 250 ms tick words.
// ============================================================================
// Every accepted input word is one tick and yields exactly one result word
// with the six lamp states that hold during that tick. The block takes one
// tick per clock cycle: the whole control update, including phase changes
// and the start of a crossing or follow-up, is one pass of next-state logic
// into the state registers, and the lamp register is the result register.
// A new tick is taken whenever the result register is empty or being read
// in the same cycle. Timing registers may be written only while idle.
// ============================================================================
`default_nettype none

module pedestrian_traffic_light_sequencer #(
    parameter int COUNT_WIDTH = ptls_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // Tick input.
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire                                   s_button_pressed,
    // Lamp results.
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic                                  m_car_green,
    output logic                                  m_car_yellow,
    output logic                                  m_car_red,
    output logic                                  m_ped_green,
    output logic                                  m_ped_yellow,
    output logic                                  m_ped_red,
    // Configuration writes.
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [ptls_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire  [ptls_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    logic [COUNT_WIDTH-1:0] phase_lim;
    logic [COUNT_WIDTH-1:0] blink_lim;
    logic [COUNT_WIDTH-1:0] hold_lim;

    ptls_pkg::ctrl_t        ctrl_reg;
    ptls_pkg::ctrl_t        ctrl_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   m_valid_reg;
    logic                   s_accept;

    // Timing registers.
    ptls_cfg_regs #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .phase_lim (phase_lim),
        .blink_lim (blink_lim),
        .hold_lim  (hold_lim)
    );

    // Next-state logic for one tick.
    ptls_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .ctrl           (ctrl_reg),
        .cnt            (cnt_reg),
        .button_pressed (s_button_pressed),
        .phase_lim      (phase_lim),
        .blink_lim      (blink_lim),
        .hold_lim       (hold_lim),
        .ctrl_next      (ctrl_next),
        .cnt_next       (cnt_next)
    );

    // A tick is taken when the result register is free or being emptied.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // State and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg    <= '{car_phase: ptls_pkg::PHASE_RED,
                             sub_step: ptls_pkg::SUB_POLL,
                             request_pending: 1'b0,
                             crossing_followup: 1'b0,
                             lamps: '0};
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                ctrl_reg <= ctrl_next;
                cnt_reg  <= cnt_next;
            end
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The lamp field of the state is the result word.
    assign m_valid      = m_valid_reg;
    assign m_car_green  = |(ctrl_reg.lamps & ptls_pkg::LAMP_CG);
    assign m_car_yellow = |(ctrl_reg.lamps & ptls_pkg::LAMP_CY);
    assign m_car_red    = |(ctrl_reg.lamps & ptls_pkg::LAMP_CR);
    assign m_ped_green  = |(ctrl_reg.lamps & ptls_pkg::LAMP_PG);
    assign m_ped_yellow = |(ctrl_reg.lamps & ptls_pkg::LAMP_PY);
    assign m_ped_red    = |(ctrl_reg.lamps & ptls_pkg::LAMP_PR);

    // An accepted tick always shows up as a result in the next cycle.
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid)
        else $error("accepted tick produced no result");

    // Pedestrian green and red are never lit together.
    a_ped_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_ped_green && m_ped_red))
        else $error("pedestrian green and red lit together");

    // During the pedestrian hold, pedestrian green and car red are lit.
    a_hold_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg.sub_step == ptls_pkg::SUB_XHOLD) |-> (m_ped_green && m_car_red))
        else $error("crossing hold without pedestrian green and car red");

    // A follow-up never overlaps a crossing.
    a_followup_no_cross: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.crossing_followup |->
            (ctrl_reg.sub_step != ptls_pkg::SUB_XBLINK &&
             ctrl_reg.sub_step != ptls_pkg::SUB_XHOLD))
        else $error("crossing step while follow-up is active");

endmodule

`default_nettype wire
